// ----- sv/u8cp_pkg.sv -----
package u8cp_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned CodeW      = 21;
  localparam int unsigned IndexBitsD = 17;
  localparam int unsigned OutDataW   = ((CodeW + 7) / 8) * 8;

  localparam logic [7:0] LeadMask1 = 8'h7f;
  localparam logic [7:0] LeadMask2 = 8'he0;
  localparam logic [7:0] LeadTag2  = 8'hc0;
  localparam logic [7:0] LeadMask3 = 8'hf0;
  localparam logic [7:0] LeadTag3  = 8'he0;
  localparam logic [7:0] ContMask  = 8'h3f;
  localparam logic [7:0] Bits2Mask = 8'h1f;
  localparam logic [7:0] Bits3Mask = 8'h0f;
  localparam logic [7:0] Bits4Mask = 8'h07;

  typedef struct packed {
    logic             emit;
    logic             found;
    logic [CodeW-1:0] code_point;
  } result_t;

endpackage

// ----- sv/u8cp_step.sv -----
module u8cp_step #(
  parameter int unsigned INDEX_BITS = u8cp_pkg::IndexBitsD
) (
  input  logic [u8cp_pkg::ByteW-1:0] text_byte_i,
  input  logic                       query_start_i,
  input  logic [INDEX_BITS-1:0]      char_index_i,
  input  logic                       active_i,
  input  logic [1:0]                 bytes_left_i,
  input  logic [u8cp_pkg::CodeW-1:0] accum_i,
  input  logic [INDEX_BITS-1:0]      chars_done_i,
  input  logic [INDEX_BITS-1:0]      target_i,
  output logic                       active_o,
  output logic [1:0]                 bytes_left_o,
  output logic [u8cp_pkg::CodeW-1:0] accum_o,
  output logic [INDEX_BITS-1:0]      chars_done_o,
  output logic [INDEX_BITS-1:0]      target_o,
  output u8cp_pkg::result_t          result_o
);

  always_comb begin
    logic                       act;
    logic [1:0]                 bl;
    logic [u8cp_pkg::CodeW-1:0] acc;
    logic [INDEX_BITS-1:0]      cd;
    logic [INDEX_BITS-1:0]      tp;
    logic [7:0]                 b;

    b   = text_byte_i;
    act = active_i;
    bl  = bytes_left_i;
    acc = accum_i;
    cd  = chars_done_i;
    tp  = target_i;
    result_o = '0;

    if (query_start_i) begin
      bl  = '0;
      acc = '0;
      cd  = '0;
      tp  = char_index_i;
      act = ~char_index_i[INDEX_BITS-1];
      if (char_index_i[INDEX_BITS-1]) begin
        result_o.emit = 1'b1;
      end
    end

    if (act) begin
      if (bl == 2'd0) begin
        if ((b & ~u8cp_pkg::LeadMask1) == 8'h00) begin
          acc = u8cp_pkg::CodeW'(b);
          bl  = 2'd0;
        end else if ((b & u8cp_pkg::LeadMask2) == u8cp_pkg::LeadTag2) begin
          acc = u8cp_pkg::CodeW'(b & u8cp_pkg::Bits2Mask);
          bl  = 2'd1;
        end else if ((b & u8cp_pkg::LeadMask3) == u8cp_pkg::LeadTag3) begin
          acc = u8cp_pkg::CodeW'(b & u8cp_pkg::Bits3Mask);
          bl  = 2'd2;
        end else begin
          acc = u8cp_pkg::CodeW'(b & u8cp_pkg::Bits4Mask);
          bl  = 2'd3;
        end
      end else begin
        acc = {acc[u8cp_pkg::CodeW-7:0], b[5:0] & u8cp_pkg::ContMask[5:0]};
        bl  = bl - 2'd1;
      end

      if (bl == 2'd0) begin
        if (cd == tp) begin
          act = 1'b0;
          result_o.emit       = 1'b1;
          result_o.found      = 1'b1;
          result_o.code_point = acc;
        end else if (acc == '0) begin
          act = 1'b0;
          result_o.emit = 1'b1;
        end else begin
          cd = cd + INDEX_BITS'(1);
        end
      end
    end

    active_o     = act;
    bytes_left_o = bl;
    accum_o      = acc;
    chars_done_o = cd;
    target_o     = tp;
  end

endmodule

// ----- sv/utf8_code_point_at_index_core.sv -----
// Finds the code point at a character index of a zero-terminated UTF-8 string
// fed one byte per transfer; the first byte of a query has tuser set and
// carries the index. Each byte is registered, decoded in one pass against the
// running state and the answer lands in the output register, so a byte can be
// taken every cycle while the output is free or being drained. Exactly one result
// follows each query that reaches its index, a zero before it, or a negative
// index; other bytes give none, and bytes after an answer are dropped until the
// next query start.
module utf8_code_point_at_index_core #(
  parameter int unsigned INDEX_BITS = u8cp_pkg::IndexBitsD
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  // text_byte [7:0], char_index [8 +: INDEX_BITS], zero padding
  input  logic [((u8cp_pkg::ByteW + INDEX_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata_i,
  // query_start
  input  logic s_axis_tuser_i,
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i,
  // code_point [20:0], zero padding
  output logic [u8cp_pkg::OutDataW-1:0] m_axis_tdata_o,
  // found
  output logic m_axis_tuser_o
);

  localparam int unsigned OutPad = u8cp_pkg::OutDataW - u8cp_pkg::CodeW;

  logic                       in_valid_q;
  logic [u8cp_pkg::ByteW-1:0] byte_q;
  logic                       start_q;
  logic [INDEX_BITS-1:0]      index_q;

  logic                       active_q, active_d;
  logic [1:0]                 bytes_left_q, bytes_left_d;
  logic [u8cp_pkg::CodeW-1:0] accum_q, accum_d;
  logic [INDEX_BITS-1:0]      chars_done_q, chars_done_d;
  logic [INDEX_BITS-1:0]      target_q, target_d;

  logic                       out_valid_q;
  logic                       found_q;
  logic [u8cp_pkg::CodeW-1:0] code_q;

  u8cp_pkg::result_t res;
  logic              advance;
  logic              fire;

  assign advance         = ~out_valid_q | m_axis_tready_i;
  assign fire            = in_valid_q & advance;
  assign s_axis_tready_o = ~in_valid_q | advance;

  u8cp_step #(.INDEX_BITS(INDEX_BITS)) u_step (
    .text_byte_i   (byte_q),
    .query_start_i (start_q),
    .char_index_i  (index_q),
    .active_i      (active_q),
    .bytes_left_i  (bytes_left_q),
    .accum_i       (accum_q),
    .chars_done_i  (chars_done_q),
    .target_i      (target_q),
    .active_o      (active_d),
    .bytes_left_o  (bytes_left_d),
    .accum_o       (accum_d),
    .chars_done_o  (chars_done_d),
    .target_o      (target_d),
    .result_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      active_q     <= 1'b0;
      bytes_left_q <= '0;
      accum_q      <= '0;
      chars_done_q <= '0;
      target_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (fire) begin
        active_q     <= active_d;
        bytes_left_q <= bytes_left_d;
        accum_q      <= accum_d;
        chars_done_q <= chars_done_d;
        target_q     <= target_d;
        out_valid_q  <= res.emit;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      byte_q  <= s_axis_tdata_i[u8cp_pkg::ByteW-1:0];
      start_q <= s_axis_tuser_i;
      index_q <= s_axis_tdata_i[u8cp_pkg::ByteW +: INDEX_BITS];
    end
    if (fire && res.emit) begin
      found_q <= res.found;
      code_q  <= res.code_point;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = found_q;
  assign m_axis_tdata_o  = {{OutPad{1'b0}}, code_q};

  a_notfound_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> code_q == '0)
    else $error("not-found result carries a nonzero code point");

  a_bytes_need_active : assert property (@(posedge clk_i) disable iff (!rst_ni)
    bytes_left_q != 2'd0 |-> active_q)
    else $error("continuation bytes pending while idle");

  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> in_valid_q && out_valid_q && !m_axis_tready_i)
    else $error("input stalled without a blocked result");

  a_neg_index : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && start_q && index_q[INDEX_BITS-1] |=> out_valid_q && !found_q && !active_q)
    else $error("negative index did not answer not-found");

endmodule

// ----- test/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IW  = u8cp_pkg::IndexBitsD;
  localparam int unsigned CW  = u8cp_pkg::CodeW;
  localparam int unsigned InW = ((u8cp_pkg::ByteW + IW + 7) / 8) * 8;
  localparam int unsigned RandomBytes = 1800;

  class cp_scoreboard;
    logic [CW-1:0] accum;
    logic [1:0]    cont_left;
    logic [IW-1:0] skipped;
    logic [IW-1:0] wanted;
    bit            busy;
    u8cp_pkg::result_t answers[$];
    int mismatches;
    int results_seen;
    int hits;
    int misses;

    function new();
      accum = '0;
      cont_left = '0;
      skipped = '0;
      wanted = '0;
      busy = 1'b0;
      mismatches = 0;
      results_seen = 0;
      hits = 0;
      misses = 0;
    endfunction

    function void push_answer(bit hit, logic [CW-1:0] cp);
      u8cp_pkg::result_t r;
      r.emit = 1'b1;
      r.found = hit;
      r.code_point = hit ? cp : '0;
      answers.push_back(r);
    endfunction

    // returns 1 when the byte is consumed rather than dropped
    function bit note_byte(logic [7:0] b, bit start, logic [IW-1:0] idx);
      if (start) begin
        busy = 1'b0;
        cont_left = '0;
        accum = '0;
        skipped = '0;
        wanted = idx;
        if (idx[IW-1]) begin
          push_answer(1'b0, '0);
          return 1'b1;
        end
        busy = 1'b1;
      end
      if (!busy) return 1'b0;

      if (cont_left == 0) begin
        if ((b & ~u8cp_pkg::LeadMask1) == 8'h00) begin
          accum = CW'(b);
        end else if ((b & u8cp_pkg::LeadMask2) == u8cp_pkg::LeadTag2) begin
          accum = CW'(b & u8cp_pkg::Bits2Mask);
          cont_left = 2'd1;
        end else if ((b & u8cp_pkg::LeadMask3) == u8cp_pkg::LeadTag3) begin
          accum = CW'(b & u8cp_pkg::Bits3Mask);
          cont_left = 2'd2;
        end else begin
          accum = CW'(b & u8cp_pkg::Bits4Mask);
          cont_left = 2'd3;
        end
      end else begin
        accum = (accum << 6) | CW'(b & u8cp_pkg::ContMask);
        cont_left = cont_left - 2'd1;
      end

      if (cont_left != 0) return 1'b1;
      if (skipped == wanted) begin
        busy = 1'b0;
        push_answer(1'b1, accum);
      end else if (accum == '0) begin
        busy = 1'b0;
        push_answer(1'b0, '0);
      end else begin
        skipped = skipped + 1'b1;
      end
      return 1'b1;
    endfunction

    function void check_result(bit hit, logic [CW-1:0] cp);
      u8cp_pkg::result_t want;
      results_seen++;
      if (answers.size() == 0) begin
        $error("unexpected result: found %0b, code_point 0x%06h", hit, cp);
        mismatches++;
        return;
      end
      want = answers.pop_front();
      if (hit !== want.found) begin
        $error("found: expected %0b, got %0b", want.found, hit);
        mismatches++;
      end
      if (cp !== want.code_point) begin
        $error("code_point: expected 0x%06h, got 0x%06h", want.code_point, cp);
        mismatches++;
      end
      if (want.found) hits++;
      else misses++;
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [InW-1:0]                s_tdata = '0;
  logic                          s_tuser = 1'b0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [u8cp_pkg::OutDataW-1:0] m_tdata;
  logic                          m_tuser;

  cp_scoreboard sb;
  logic [7:0]   text_q[$];
  int           burst_left = 0;
  int           used_bytes = 0;
  int           sent_bytes = 0;
  int           queries = 0;
  logic [15:0]  stall_pat = '0;
  int           pat_left = 0;

  utf8_code_point_at_index_core dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // receiver back-pressure: rotating pattern, reloaded now and then
  always @(posedge clk) begin
    if (pat_left == 0) begin
      stall_pat = ($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom);
      pat_left = $urandom_range(16, 80);
    end
    stall_pat = {stall_pat[14:0], stall_pat[15]};
    pat_left--;
    m_tready <= stall_pat[0];
  end

  always @(posedge clk) begin
    if (rst_n && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata[CW-1:0]);
  end

  task automatic put_byte(input logic [7:0] b, input bit start, input logic [IW-1:0] idx);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= InW'({idx, b});
    s_tuser  <= start;
    do @(posedge clk); while (!s_tready);
    sent_bytes++;
    if (sb.note_byte(b, start, idx)) used_bytes++;
  endtask

  task automatic send_text(input logic [IW-1:0] idx);
    queries++;
    foreach (text_q[i]) put_byte(text_q[i], i == 0, (i == 0) ? idx : IW'($urandom));
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.answers.size() != 0);
  endtask

  function automatic void push_char();
    int unsigned len;
    len = $urandom_range(1, 4);
    case (len)
      1: text_q.push_back(8'($urandom_range(1, 127)));
      2: text_q.push_back(8'hc0 | 8'($urandom_range(0, 31)));
      3: text_q.push_back(8'he0 | 8'($urandom_range(0, 15)));
      default: begin
        if ($urandom_range(0, 1) != 0) text_q.push_back(8'hf0 | 8'($urandom_range(0, 15)));
        else text_q.push_back(8'h80 | 8'($urandom_range(0, 63)));
      end
    endcase
    repeat (len - 1) begin
      if ($urandom_range(0, 7) == 0) text_q.push_back(8'($urandom));
      else text_q.push_back(8'h80 | 8'($urandom_range(0, 63)));
    end
  endfunction

  function automatic void build_text(int unsigned n_chars, bit terminate);
    text_q.delete();
    repeat (n_chars) push_char();
    if (terminate) text_q.push_back(8'h00);
    repeat ($urandom_range(0, 3)) text_q.push_back(8'($urandom));
  endfunction

  task automatic random_query(input bit broken);
    logic [IW-1:0] idx;
    int unsigned   pick;
    int unsigned   k;
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      idx = IW'(-int'($urandom_range(1, 65536)));
      text_q.delete();
      text_q.push_back(8'($urandom));
      repeat ($urandom_range(0, 2)) text_q.push_back(8'($urandom));
    end else if (pick < 12) begin
      idx = IW'($urandom_range(64, 65535));
      build_text($urandom_range(0, 8), 1'b1);
    end else begin
      k = $urandom_range(0, 6);
      idx = IW'(k);
      if ($urandom_range(0, 3) == 0) build_text($urandom_range(0, k), 1'b1);
      else build_text(k + $urandom_range(1, 3), $urandom_range(0, 1));
    end
    if (broken && text_q.size() > 1) text_q = text_q[0:$urandom_range(0, text_q.size() - 2)];
    send_text(idx);
  endtask

  initial begin
    int unsigned pick;
    int          base;
    bit          paused;
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // byte with no query open
    put_byte(8'h41, 1'b0, '0);
    // terminator at index 0 is returned as a found zero
    text_q = '{8'h00};
    send_text('0);
    // negative indexes, including the most negative
    text_q = '{8'h41};
    send_text(IW'(-1));
    text_q = '{8'hff};
    send_text(IW'(-65536));
    text_q = '{8'h41, 8'hc3, 8'ha9};
    send_text(IW'(1));
    text_q = '{8'he2, 8'h82, 8'hac, 8'h7f, 8'hff, 8'hbf, 8'hbf, 8'hbf};
    send_text(IW'(2));
    // largest index, string ends first
    text_q = '{8'h61, 8'h00};
    send_text(IW'(65535));
    // terminator inside a multibyte character, then a dropped byte
    text_q = '{8'h62, 8'he0, 8'h00, 8'h00, 8'h55};
    send_text(IW'(3));
    // new query start cuts the old one short
    text_q = '{8'h41};
    send_text(IW'(5));
    text_q = '{8'hf0, 8'h90, 8'h80, 8'h80};
    send_text('0);
    drain();

    base = sent_bytes;
    paused = 1'b0;
    while (sent_bytes - base < RandomBytes) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        repeat ($urandom_range(1, 6))
          put_byte(8'($urandom), $urandom_range(0, 5) == 0, IW'($urandom));
      end else begin
        random_query(pick < 18);
      end
      if (!paused && sent_bytes - base > RandomBytes / 2) begin
        drain();
        paused = 1'b1;
      end
    end

    drain();
    repeat (8) @(posedge clk);
    $display("Ran %0d queries, %0d bytes decoded; %0d results checked (%0d found, %0d not found).",
             queries, used_bytes, sb.results_seen, sb.hits, sb.misses);
    if (sb.mismatches == 0) begin
      $display("PASS utf8_code_point_at_index_core");
    end else begin
      $display("FAIL utf8_code_point_at_index_core");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAIL utf8_code_point_at_index_core");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/u8cp_pkg.sv
sv/u8cp_step.sv
sv/utf8_code_point_at_index_core.sv
test/testbench.sv
